/* rtl/tts_pkg.sv */
package tts_pkg;

   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROW_COUNT = 25;

   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = 11;
   localparam int POS_W = 11;
   localparam int CELL_W = 16;

   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [BYTE_W-1:0] BLANK_ATTR_RESET = 8'h0F;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR      = 3'd0,
      KIND_BACKSPACE = 3'd1,
      KIND_LEFT      = 3'd2,
      KIND_RIGHT     = 3'd3,
      KIND_READ      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CLS_MOVE,
      CLS_WRITE,
      CLS_READ
   } req_class_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_COPY,
      ST_DRAIN,
      ST_BLANK,
      ST_WRITE,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take_req;
      logic do_decode;
      logic clear_step;
      logic scroll_start;
      logic copy_step;
      logic blank_init;
      logic blank_step;
      logic scroll_done;
      logic write_cell;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      req_class_type req_class;
      logic          sweep_last;
      logic          cursor_at_end;
      logic          rsp_free;
   } status_type;

endpackage

/* rtl/tts_channels.sv */
interface tts_req_if import tts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] char_code;
   logic [BYTE_W-1:0] color;
   logic [ADDR_W-1:0] cell_address;

   modport source (output valid, kind, char_code, color, cell_address, input ready);
   modport sink (input valid, kind, char_code, color, cell_address, output ready);
endinterface

interface tts_rsp_if import tts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  cursor_pos;
   logic [CELL_W-1:0] read_data;

   modport source (output valid, cursor_pos, read_data, input ready);
   modport sink (input valid, cursor_pos, read_data, output ready);
endinterface

interface tts_csr_if import tts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] blank_attribute;

   modport source (output valid, blank_attribute, input ready);
   modport sink (input valid, blank_attribute, output ready);
endinterface

/* rtl/text_terminal_cursor_scroll.sv */
// Channel   Direction  Transfer when        Payload
// req_bus   in         valid && ready       kind, char_code, color, cell_address
// rsp_bus   out        valid && ready       cursor_pos, read_data
// csr_bus   in         valid && ready       blank_attribute
//
// A move, newline or unused kind passes decode and finish before the next accept, a read
// also the read state and a written character or backspace the check and write states.
// A write at the end of the screen first runs a sweep, one cell per cycle with a
// read and a write port on the screen memory, to move every row up and blank the last one.
// After reset a clearing pass over every cell runs before the first accept.
// A waiting response holds the item in its final state and keeps the input closed.
module text_terminal_cursor_scroll import tts_pkg::*; #(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROW_COUNT = DEFAULT_ROW_COUNT
) (
   input logic        clock,
   input logic        reset,
   tts_req_if.sink    req_bus,
   tts_rsp_if.source  rsp_bus,
   tts_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   tts_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tts_datapath #(
      .COLUMNS   (COLUMNS),
      .ROW_COUNT (ROW_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_bus.kind),
      .req_char_code       (req_bus.char_code),
      .req_color           (req_bus.color),
      .req_cell_address    (req_bus.cell_address),
      .csr_valid           (csr_bus.valid),
      .csr_blank_attribute (csr_bus.blank_attribute),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_cursor_pos      (rsp_bus.cursor_pos),
      .rsp_read_data       (rsp_bus.read_data)
   );

`ifndef SYNTH
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input accepted while an item is still in progress");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.cursor_pos <= COLUMNS * ROW_COUNT))
      else $error("cursor position beyond the screen size");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.copy_step, cmd.blank_step, cmd.write_cell}))
      else $error("more than one screen memory operation commanded");

   a_no_accept_during_scroll: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_step || cmd.blank_step || cmd.clear_step) |-> !req_bus.ready)
      else $error("input ready during a screen sweep");
`endif

endmodule

/* rtl/tts_control.sv */
module tts_control import tts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.do_decode = 1'b1;
            unique case (status.req_class)
               CLS_WRITE: state_in = ST_CHECK;
               CLS_READ:  state_in = ST_READ;
               default:   state_in = ST_FINISH;
            endcase
         end
         ST_CHECK: begin
            if (status.cursor_at_end) begin
               cmd.scroll_start = 1'b1;
               state_in = ST_COPY;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.sweep_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.blank_init = 1'b1;
            state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.blank_step = 1'b1;
            if (status.sweep_last) begin
               cmd.scroll_done = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_cell = 1'b1;
            state_in = ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/tts_datapath.sv */
module tts_datapath import tts_pkg::*; #(
   parameter int COLUMNS = DEFAULT_COLUMNS,
   parameter int ROW_COUNT = DEFAULT_ROW_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [BYTE_W-1:0] req_char_code,
   input  logic [BYTE_W-1:0] req_color,
   input  logic [ADDR_W-1:0] req_cell_address,
   input  logic              csr_valid,
   input  logic [BYTE_W-1:0] csr_blank_attribute,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [POS_W-1:0]  rsp_cursor_pos,
   output logic [CELL_W-1:0] rsp_read_data
);

   localparam int TOTAL = COLUMNS * ROW_COUNT;
   localparam int IDX_W = $clog2(TOTAL);
   localparam int POS_IW = $clog2(TOTAL + 1);
   localparam int ROW_W = $clog2(ROW_COUNT + 1);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int AW = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;
   localparam int PW = (POS_IW > POS_W) ? POS_IW : POS_W;

   logic [CELL_W-1:0] mem [TOTAL];

   logic [KIND_W-1:0] req_kind_ff;
   logic [BYTE_W-1:0] req_char_ff;
   logic [BYTE_W-1:0] req_color_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [BYTE_W-1:0] blank_attr_ff;

   logic [POS_IW-1:0] cursor_ff, cursor_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;

   logic [POS_IW-1:0] cnt_ff;
   logic              copy_wr_ff;
   logic [IDX_W-1:0]  copy_dst_ff;
   logic [POS_IW-1:0] copy_dst_wide;
   logic [CELL_W-1:0] rdata_ff;
   logic              rd_sel_ff;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_cursor_ff;
   logic [CELL_W-1:0] rsp_data_ff;

   kind_type          kind;
   logic              is_newline;
   logic              at_end;
   logic              back_ok;
   logic [AW-1:0]     addr_wide;
   logic              addr_hit;
   logic [PW-1:0]     cursor_wide;

   logic [POS_IW-1:0] fwd_cursor, back_cursor;
   logic [ROW_W-1:0]  fwd_row, back_row;
   logic [COL_W-1:0]  fwd_col, back_col;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_idx;

   assign kind = kind_type'(req_kind_ff);
   assign is_newline = (req_char_ff == NEWLINE_CHAR);
   assign at_end = (cursor_ff >= POS_IW'(TOTAL));
   assign back_ok = (row_ff > line_ff) || ((row_ff == line_ff) && (col_ff > COL_W'(1)));
   assign addr_wide = AW'(req_addr_ff);
   assign addr_hit = (addr_wide < AW'(TOTAL));
   assign cursor_wide = PW'(cursor_ff);
   assign copy_dst_wide = cnt_ff - POS_IW'(COLUMNS);

   // The cursor is kept together with its row and column so that a newline
   // needs only one add.
   always_comb begin
      fwd_cursor = cursor_ff + POS_IW'(1);
      back_cursor = cursor_ff - POS_IW'(1);
      if (col_ff == COL_W'(COLUMNS - 1)) begin
         fwd_col = '0;
         fwd_row = row_ff + ROW_W'(1);
      end else begin
         fwd_col = col_ff + COL_W'(1);
         fwd_row = row_ff;
      end
      if (col_ff == '0) begin
         back_col = COL_W'(COLUMNS - 1);
         back_row = row_ff - ROW_W'(1);
      end else begin
         back_col = col_ff - COL_W'(1);
         back_row = row_ff;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      row_in = row_ff;
      col_in = col_ff;
      line_in = line_ff;
      if (cmd.do_decode) begin
         case (kind) inside
            KIND_CHAR: begin
               if (is_newline) begin
                  if (row_ff >= ROW_W'(ROW_COUNT - 1)) begin
                     cursor_in = POS_IW'(TOTAL);
                     row_in = ROW_W'(ROW_COUNT);
                     line_in = ROW_W'(ROW_COUNT);
                  end else begin
                     cursor_in = cursor_ff + (POS_IW'(COLUMNS) - POS_IW'(col_ff));
                     row_in = row_ff + ROW_W'(1);
                     line_in = row_ff + ROW_W'(1);
                  end
                  col_in = '0;
               end
            end
            KIND_BACKSPACE, KIND_LEFT: begin
               if (back_ok) begin
                  cursor_in = back_cursor;
                  row_in = back_row;
                  col_in = back_col;
               end
            end
            KIND_RIGHT: begin
               if (!at_end) begin
                  cursor_in = fwd_cursor;
                  row_in = fwd_row;
                  col_in = fwd_col;
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.scroll_done) begin
         cursor_in = POS_IW'(TOTAL - COLUMNS);
         row_in = ROW_W'(ROW_COUNT - 1);
         col_in = '0;
         line_in = ROW_W'(ROW_COUNT - 1);
      end else if (cmd.write_cell && (kind == KIND_CHAR)) begin
         cursor_in = fwd_cursor;
         row_in = fwd_row;
         col_in = fwd_col;
      end
   end

   always_comb begin
      status.req_class = CLS_MOVE;
      status.sweep_last = (cnt_ff == POS_IW'(TOTAL - 1));
      status.cursor_at_end = at_end;
      status.rsp_free = !rsp_valid_ff || rsp_ready;
      case (kind) inside
         KIND_CHAR:      status.req_class = is_newline ? CLS_MOVE : CLS_WRITE;
         KIND_BACKSPACE: status.req_class = CLS_WRITE;
         KIND_READ:      status.req_class = CLS_READ;
         default:        status.req_class = CLS_MOVE;
      endcase
   end

   always_comb begin
      wr_en = 1'b0;
      wr_idx = cnt_ff[IDX_W-1:0];
      wr_data = {BLANK_ATTR_RESET, SPACE_CHAR};
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (copy_wr_ff) begin
         wr_en = 1'b1;
         wr_idx = copy_dst_ff;
         wr_data = rdata_ff;
      end else if (cmd.blank_step) begin
         wr_en = 1'b1;
         wr_data = {blank_attr_ff, SPACE_CHAR};
      end else if (cmd.write_cell) begin
         wr_en = 1'b1;
         wr_idx = cursor_ff[IDX_W-1:0];
         wr_data = {req_color_ff, (kind == KIND_CHAR) ? req_char_ff : SPACE_CHAR};
      end
   end

   assign rd_en = cmd.copy_step || (cmd.do_decode && (kind == KIND_READ) && addr_hit);
   assign rd_idx = cmd.copy_step ? cnt_ff[IDX_W-1:0] : addr_wide[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_kind_ff <= req_kind;
         req_char_ff <= req_char_code;
         req_color_ff <= req_color;
         req_addr_ff <= req_cell_address;
      end
      if (cmd.do_decode) rd_sel_ff <= (kind == KIND_READ) && addr_hit;
      copy_dst_ff <= copy_dst_wide[IDX_W-1:0];
      if (cmd.load_rsp) begin
         rsp_cursor_ff <= cursor_wide[POS_W-1:0];
         rsp_data_ff <= rd_sel_ff ? rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= BLANK_ATTR_RESET;
         cursor_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         line_ff <= '0;
         cnt_ff <= '0;
         copy_wr_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) blank_attr_ff <= csr_blank_attribute;
         cursor_ff <= cursor_in;
         row_ff <= row_in;
         col_ff <= col_in;
         line_ff <= line_in;
         if (cmd.scroll_start) begin
            cnt_ff <= POS_IW'(COLUMNS);
         end else if (cmd.blank_init) begin
            cnt_ff <= POS_IW'(TOTAL - COLUMNS);
         end else if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
            cnt_ff <= cnt_ff + POS_IW'(1);
         end
         copy_wr_ff <= cmd.copy_step;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

/* verif/text_terminal_cursor_scroll_test.sv */
`timescale 1ns / 100ps

module text_terminal_cursor_scroll_test import tts_pkg::*; ();

   localparam int COLUMNS = DEFAULT_COLUMNS;
   localparam int ROW_COUNT = DEFAULT_ROW_COUNT;
   localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;
   localparam int ADDR_TOP = (1 << ADDR_W) - 1;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LOW = KIND_W'(KIND_READ + 1);
   localparam logic [KIND_W-1:0] KIND_UNUSED_HIGH = '1;
   localparam int SETTLE_CYCLES = 12;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_ITEMS = 150;
   localparam int PHASE_ITEMS = 92;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] char_code;
      logic [BYTE_W-1:0] color;
      logic [ADDR_W-1:0] cell_address;
   } keystroke_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] read_data;
   } reply_type;

   // Mirror of the screen, the cursor and the current row, kept in step with every transfer.
   class terminal_mirror;
      logic [CELL_W-1:0] cells [CELL_TOTAL];
      int unsigned       cursor;
      int unsigned       row_index;
      logic [BYTE_W-1:0] blank_attr;
      reply_type         due_replies [$];
      int                mismatches;

      function new();
         blank_attr = BLANK_ATTR_RESET;
         foreach (cells[i]) cells[i] = {blank_attr, SPACE_CHAR};
         cursor = 0;
         row_index = 0;
         mismatches = 0;
      endfunction

      function void scroll_rows();
         for (int i = 0; i < CELL_TOTAL; i++) begin
            if (i < CELL_TOTAL - COLUMNS) begin
               cells[i] = cells[i + COLUMNS];
            end else begin
               cells[i] = {blank_attr, SPACE_CHAR};
            end
         end
         cursor = CELL_TOTAL - COLUMNS;
         row_index = ROW_COUNT - 1;
      endfunction

      function void put_cell(logic [BYTE_W-1:0] attr, logic [BYTE_W-1:0] ch);
         if (cursor >= CELL_TOTAL) scroll_rows();
         cells[cursor] = {attr, ch};
      endfunction

      function void step_back();
         if (cursor > row_index * COLUMNS + 1) cursor--;
      endfunction

      function void apply_keystroke(keystroke_type k);
         logic [CELL_W-1:0] cell_read;
         cell_read = '0;
         case (k.kind)
            KIND_CHAR: begin
               if (k.char_code == NEWLINE_CHAR) begin
                  if (cursor >= CELL_TOTAL - COLUMNS) begin
                     cursor = CELL_TOTAL;
                     row_index = ROW_COUNT;
                  end else begin
                     cursor = (cursor / COLUMNS + 1) * COLUMNS;
                     row_index = cursor / COLUMNS;
                  end
               end else begin
                  put_cell(k.color, k.char_code);
                  cursor++;
               end
            end
            KIND_BACKSPACE: begin
               step_back();
               put_cell(k.color, SPACE_CHAR);
            end
            KIND_LEFT: begin
               step_back();
            end
            KIND_RIGHT: begin
               if (cursor < CELL_TOTAL) cursor++;
            end
            KIND_READ: begin
               if (k.cell_address < CELL_TOTAL) cell_read = cells[k.cell_address];
            end
            default: begin
            end
         endcase
         due_replies.push_back('{cursor_pos: POS_W'(cursor), read_data: cell_read});
      endfunction

      task report_mismatch(input string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_reply(input logic [POS_W-1:0] pos, input logic [CELL_W-1:0] data);
         reply_type due;
         if (due_replies.size() == 0) begin
            report_mismatch($sformatf("reply with none pending, cursor %0d data %h", pos, data));
         end else begin
            due = due_replies.pop_front();
            if (pos !== due.cursor_pos) begin
               report_mismatch($sformatf("cursor_pos %0d, predicted %0d", pos, due.cursor_pos));
            end
            if (data !== due.read_data) begin
               report_mismatch($sformatf("read_data %h, predicted %h", data, due.read_data));
            end
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   items_sent = 0;
   bit   rsp_hold = 1'b0;
   bit   rsp_idling = 1'b0;
   bit   req_idling = 1'b0;

   terminal_mirror mirror = new();

   tts_req_if req_bus ();
   tts_rsp_if rsp_bus ();
   tts_csr_if csr_bus ();

   text_terminal_cursor_scroll dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   function automatic int stall_length();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end else begin
         return $urandom_range(1, 3);
      end
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'($urandom);
   endfunction

   function automatic keystroke_type make_key(logic [KIND_W-1:0] kind,
                                              logic [BYTE_W-1:0] char_code,
                                              logic [BYTE_W-1:0] color,
                                              logic [ADDR_W-1:0] cell_address);
      keystroke_type k;
      k.kind = kind;
      k.char_code = char_code;
      k.color = color;
      k.cell_address = cell_address;
      return k;
   endfunction

   // Called at a falling edge; returns at a falling edge, with valid possibly still high.
   task automatic offer(input keystroke_type k);
      req_bus.valid = 1'b1;
      req_bus.kind = k.kind;
      req_bus.char_code = k.char_code;
      req_bus.color = k.color;
      req_bus.cell_address = k.cell_address;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      mirror.apply_keystroke(k);
      if (k.kind <= KIND_READ) items_sent++;
      @(negedge clock);
      if (req_idling && $urandom_range(0, 99) < 40) begin
         req_bus.valid = 1'b0;
         repeat (stall_length()) @(negedge clock);
      end
   endtask

   task automatic settle_replies();
      req_bus.valid = 1'b0;
      while (mirror.due_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_blank_attribute(input logic [BYTE_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.blank_attribute = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      mirror.blank_attr = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_newline();
      offer(make_key(KIND_CHAR, NEWLINE_CHAR, rand_byte(), rand_addr()));
   endtask

   // Drives the cursor past the last row and exercises the saturating and scrolling cases.
   task automatic reach_screen_end();
      while (mirror.cursor < CELL_TOTAL) send_newline();
      offer(make_key(KIND_RIGHT, rand_byte(), rand_byte(), rand_addr()));
      offer(make_key(KIND_LEFT, rand_byte(), rand_byte(), rand_addr()));
      offer(make_key(KIND_BACKSPACE, rand_byte(), rand_byte(), rand_addr()));
      offer(make_key(KIND_READ, rand_byte(), rand_byte(), ADDR_W'(CELL_TOTAL - 1)));
      send_newline();
      offer(make_key(KIND_CHAR, 8'h41, rand_byte(), rand_addr()));
      offer(make_key(KIND_READ, rand_byte(), rand_byte(), ADDR_W'(CELL_TOTAL - COLUMNS)));
   endtask

   task automatic run_phase(input int count, input bit pause_midway);
      int                start;
      int                pick;
      bit                paused;
      int unsigned       addr;
      logic [BYTE_W-1:0] ink;
      logic [BYTE_W-1:0] ch;
      start = items_sent;
      paused = 1'b0;
      reach_screen_end();
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            ink = rand_byte();
            repeat ($urandom_range(1, 30)) begin
               ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : rand_byte();
               if ($urandom_range(0, 7) == 0) ink = rand_byte();
               offer(make_key(KIND_CHAR, ch, ink, rand_addr()));
            end
         end else if (pick < 52) begin
            repeat ($urandom_range(3, 26)) send_newline();
         end else if (pick < 68) begin
            repeat ($urandom_range(1, 8)) begin
               offer(make_key(KIND_W'(KIND_BACKSPACE + $urandom_range(0, 2)), rand_byte(),
                              rand_byte(), rand_addr()));
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 1) begin
                  addr = (mirror.cursor > 90) ? mirror.cursor - $urandom_range(0, 90)
                                              : $urandom_range(0, mirror.cursor);
               end else begin
                  addr = $urandom_range(0, ADDR_TOP);
               end
               offer(make_key(KIND_READ, rand_byte(), rand_byte(), ADDR_W'(addr)));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               offer(make_key(KIND_W'($urandom_range(0, KIND_UNUSED_HIGH)), rand_byte(),
                              rand_byte(), rand_addr()));
            end
         end
         if (pause_midway && !paused && items_sent - start >= count / 2) begin
            settle_replies();
            paused = 1'b1;
         end
      end
   endtask

   initial begin : reply_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (rsp_idling && $urandom_range(0, 99) < 25) stall_left = stall_length();
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            mirror.check_reply(rsp_bus.cursor_pos, rsp_bus.read_data);
         end
      end
   end

   // A long refusal of replies while requests keep coming, so that the block backs up.
   initial begin : reply_hold
      wait (items_sent >= HOLD_AFTER_ITEMS);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   initial begin : watchdog
      #200_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_CHAR;
      req_bus.char_code = '0;
      req_bus.color = '0;
      req_bus.cell_address = '0;
      csr_bus.valid = 1'b0;
      csr_bus.blank_attribute = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      req_idling = 1'b1;
      rsp_idling = 1'b1;

      offer(make_key(KIND_READ, 8'h00, 8'h00, '0));
      offer(make_key(KIND_LEFT, 8'hFF, 8'hFF, '1));
      offer(make_key(KIND_BACKSPACE, 8'h00, 8'h3C, '0));
      offer(make_key(KIND_CHAR, 8'h41, 8'hFF, '0));
      offer(make_key(KIND_CHAR, 8'h00, 8'h00, '1));
      offer(make_key(KIND_CHAR, 8'hFF, 8'h80, '0));
      offer(make_key(KIND_BACKSPACE, 8'h55, 8'h7E, '0));
      offer(make_key(KIND_LEFT, 8'h00, 8'h00, '0));
      offer(make_key(KIND_LEFT, 8'h00, 8'h00, '0));
      offer(make_key(KIND_RIGHT, 8'h00, 8'h00, '0));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(0)));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(1)));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(CELL_TOTAL - 1)));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(CELL_TOTAL)));
      offer(make_key(KIND_READ, 8'hFF, 8'hFF, ADDR_W'(ADDR_TOP)));
      offer(make_key(KIND_CHAR, NEWLINE_CHAR, 8'h12, '0));
      offer(make_key(KIND_BACKSPACE, 8'h00, 8'hC3, '0));
      offer(make_key(KIND_CHAR, 8'h7A, 8'h2E, '0));
      offer(make_key(KIND_LEFT, 8'h00, 8'h00, '0));
      offer(make_key(KIND_UNUSED_LOW, 8'h41, 8'h07, ADDR_W'(0)));
      offer(make_key(KIND_UNUSED_HIGH, 8'hFF, 8'hFF, '1));
      offer(make_key(KIND_RIGHT, 8'h00, 8'h00, '0));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(COLUMNS)));
      offer(make_key(KIND_READ, 8'h00, 8'h00, ADDR_W'(COLUMNS + 1)));

      settle_replies();
      write_blank_attribute(8'h00);
      run_phase(PHASE_ITEMS, 1'b0);

      settle_replies();
      write_blank_attribute(8'hFF);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      run_phase(PHASE_ITEMS, 1'b1);

      settle_replies();
      write_blank_attribute(rand_byte());
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      run_phase(PHASE_ITEMS, 1'b0);

      settle_replies();
      if (mirror.mismatches == 0 && mirror.due_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
